### rtl/core/assert_macros.svh
// Assertion macros shared by the checker files of this project.
// No dependencies; take in by include before the module header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/pwmtsm_pkg.sv
// Shared types and constants of the PWM timer with shadowed duty registers.
// No dependencies.
package pwmtsm_pkg;

  localparam int DATA_W          = 32;
  localparam int PWM_BITS        = 6;
  localparam int CHAN_W          = 3;
  localparam int CFG_IDX_W       = 2;
  localparam int CHANNELS_DEF    = 6;
  localparam int COUNT_WIDTH_DEF = 32;

  // Item function codes
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_DUTY = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRESCALE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHAN_ENABLE  = 2'd2;

  typedef struct packed {
    logic              func;
    logic [CHAN_W-1:0] channel;
    logic [DATA_W-1:0] duty;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0]   prescale;
    logic [DATA_W-1:0]   period_ticks;
    logic [PWM_BITS-1:0] channel_enable;
  } cfg_t;

  typedef struct packed {
    logic [PWM_BITS-1:0] pwm_out;
    logic [DATA_W-1:0]   count_value;
  } result_t;

  typedef struct packed {
    logic load;   // take a new request this edge
    logic drain;  // hand the held request on this edge
  } pipe_ctl_t;

endpackage

### rtl/core/pwm_timer_shadow_match.sv
// Top level of the PWM timer with prescaler and shadowed duty registers.
// Depends on pwmtsm_pkg, pwmtsm_cfg_regs, pwmtsm_in_reg, pwmtsm_core, pwmtsm_out_reg.
//
//   channel   handshake             payload
//   -------   -------------------   -------------------------------
//   in        in_valid / in_stall   func, channel, duty
//   out       out_valid / out_stall pwm_out, count_value
//   cfg       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One request per clock while the result is not stalled: a request sits in the
// input register, and the timer update runs in one pass from there into the
// result register.
// rst is synchronous; it resets counters, duties, pending marks and registers.
// A stalled result holds the result register; the input register keeps one
// request behind it, and in_stall rises only while both are full.
// cfg_ready is always high; write registers only while the block is idle.
module pwm_timer_shadow_match import pwmtsm_pkg::*; #(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // request channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 func,
  input  logic [CHAN_W-1:0]    channel,
  input  logic [DATA_W-1:0]    duty,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PWM_BITS-1:0]  pwm_out,
  output logic [DATA_W-1:0]    count_value,
  // register write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  cfg_t      cfg;
  item_t     in_item;
  item_t     held_item;
  logic      held_valid;
  logic      out_free;
  pipe_ctl_t in_ctl;
  result_t   result_next;

  // Pack the request fields.
  assign in_item.func    = func;
  assign in_item.channel = channel;
  assign in_item.duty    = duty;

  // Advance the held request whenever the result register can take it;
  // stall new requests only while the held one cannot move.
  assign in_ctl.drain = held_valid && out_free;
  assign in_stall     = held_valid && !out_free;
  assign in_ctl.load  = in_valid && !in_stall;

  pwmtsm_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pwmtsm_in_reg u_in_reg (
    .clk   (clk),
    .rst   (rst),
    .ctl   (in_ctl),
    .d     (in_item),
    .q     (held_item),
    .valid (held_valid)
  );

  // Timer state updates exactly once per request, as it leaves the input register.
  pwmtsm_core #(
    .CHANNELS    (CHANNELS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (in_ctl.drain),
    .item        (held_item),
    .cfg         (cfg),
    .result_next (result_next)
  );

  pwmtsm_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .load        (in_ctl.drain),
    .d           (result_next),
    .free        (out_free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pwm_out     (pwm_out),
    .count_value (count_value)
  );

endmodule

### rtl/core/pwmtsm_cfg_regs.sv
// Configuration register file of the PWM timer.
// Depends on pwmtsm_pkg.
module pwmtsm_cfg_regs import pwmtsm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  output cfg_t                 cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prescale       <= '0;
      cfg.period_ticks   <= DATA_W'(1);
      cfg.channel_enable <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PRESCALE:     cfg.prescale       <= cfg_data;
        REG_PERIOD_TICKS: cfg.period_ticks   <= cfg_data;
        REG_CHAN_ENABLE:  cfg.channel_enable <= cfg_data[PWM_BITS-1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

endmodule

### rtl/core/pwmtsm_in_reg.sv
// Input register stage: holds one accepted request for the timer core.
// Depends on pwmtsm_pkg.
module pwmtsm_in_reg import pwmtsm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  pipe_ctl_t ctl,
  input  item_t     d,
  output item_t     q,
  output logic      valid
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.load) begin
      valid <= 1'b1;
    end else if (ctl.drain) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q <= d;
    end
  end

endmodule

### rtl/core/pwmtsm_core.sv
// Timer state and one-pass update: prescaler, period counter, shadow and
// active duties, compare outputs. Depends on pwmtsm_pkg.
module pwmtsm_core import pwmtsm_pkg::*; #(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result_next
);

  localparam int CW1   = COUNT_WIDTH + 1;
  localparam int LIM_W = DATA_W + 1;

  logic [DATA_W-1:0]      prescale_count;
  logic [COUNT_WIDTH-1:0] period_count;
  logic [COUNT_WIDTH-1:0] shadow_duty [CHANNELS];
  logic [COUNT_WIDTH-1:0] active_duty [CHANNELS];
  logic [CHANNELS-1:0]    latch_pending;

  logic                   is_tick;
  logic                   presc_wrap;
  logic [DATA_W-1:0]      prescale_count_next;
  logic [CW1-1:0]         count_inc;
  logic [DATA_W-1:0]      limit;
  logic                   period_advance;
  logic                   period_wrap;
  logic [COUNT_WIDTH-1:0] period_count_next;
  logic [COUNT_WIDTH-1:0] active_next [CHANNELS];
  logic [CHANNELS-1:0]    hit;
  logic [CHANNELS-1:0]    pins;

  always_comb begin
    is_tick             = (item.func == FUNC_TICK);
    presc_wrap          = (prescale_count >= cfg.prescale);
    prescale_count_next = presc_wrap ? '0 : prescale_count + DATA_W'(1);
    count_inc           = CW1'(period_count) + CW1'(1);
    // zero period behaves as one
    limit               = (cfg.period_ticks == '0) ? DATA_W'(1) : cfg.period_ticks;
    period_advance      = is_tick && presc_wrap;
    period_wrap         = period_advance &&
                          ((LIM_W'(count_inc) >= LIM_W'(limit)) || count_inc[COUNT_WIDTH]);
    if (period_wrap) begin
      period_count_next = '0;
    end else if (period_advance) begin
      period_count_next = count_inc[COUNT_WIDTH-1:0];
    end else begin
      period_count_next = period_count;
    end
    for (int k = 0; k < CHANNELS; k++) begin
      hit[k]         = !is_tick && (item.channel == CHAN_W'(k + 1));
      active_next[k] = (period_wrap && latch_pending[k]) ? shadow_duty[k] : active_duty[k];
      pins[k]        = cfg.channel_enable[k] && (period_count_next < active_next[k]);
    end
    result_next.pwm_out     = PWM_BITS'(pins);
    result_next.count_value = DATA_W'(period_count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= '0;
      period_count   <= '0;
      latch_pending  <= '0;
      for (int k = 0; k < CHANNELS; k++) begin
        shadow_duty[k] <= '0;
        active_duty[k] <= '0;
      end
    end else if (step) begin
      if (is_tick) begin
        prescale_count <= prescale_count_next;
      end
      period_count  <= period_count_next;
      latch_pending <= period_wrap ? '0 : (latch_pending | hit);
      for (int k = 0; k < CHANNELS; k++) begin
        active_duty[k] <= active_next[k];
        if (hit[k]) begin
          shadow_duty[k] <= item.duty[COUNT_WIDTH-1:0];
        end
      end
    end
  end

endmodule

### rtl/core/pwmtsm_out_reg.sv
// Result register stage: holds one result until the consumer takes it.
// Depends on pwmtsm_pkg.
module pwmtsm_out_reg import pwmtsm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  result_t             d,
  output logic                free,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [PWM_BITS-1:0] pwm_out,
  output logic [DATA_W-1:0]   count_value
);

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pwm_out     <= d.pwm_out;
      count_value <= d.count_value;
    end
  end

endmodule

### rtl/core/pwmtsm_checker.sv
// Port-level checker for pwm_timer_shadow_match, attached by bind.
// Depends on pwmtsm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pwmtsm_checker import pwmtsm_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [PWM_BITS-1:0] pwm_out,
  input logic [DATA_W-1:0]   count_value,
  input logic                cfg_ready
);

  // A stalled result keeps its payload.
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(pwm_out) && $stable(count_value))
  // Requests back up only behind a stalled result.
  `ASSERT_IMPLIES(a_stall_cause, clk, rst, in_stall, out_valid && out_stall)
  // A new result comes from an accepted request that has passed through the input register.
  `ASSERT_IMPLIES(a_out_source, clk, rst, $rose(out_valid), $past(rst, 2) || $past(in_valid && !in_stall, 2))
  // Register writes are never refused.
  `ASSERT_ALWAYS(a_cfg_ready, clk, rst, cfg_ready)

endmodule

bind pwm_timer_shadow_match pwmtsm_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .pwm_out     (pwm_out),
  .count_value (count_value),
  .cfg_ready   (cfg_ready)
);

### bench/pwm_timer_shadow_match_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the PWM timer with prescaler and shadowed duties.
// Depends on pwmtsm_pkg and pwm_timer_shadow_match; tick and duty requests
// are checked one by one against a cycle-free timer predictor.
module pwm_timer_shadow_match_tb;
  import pwmtsm_pkg::*;

  localparam int NUM_DIRECTED = 34;
  localparam int NUM_PHASES   = 9;
  localparam int PHASE_ITEMS  = 67;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One line of the directed table: either a register write or a request,
  // optionally with the result typed in by hand.
  typedef struct {
    row_kind_t           kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [DATA_W-1:0]   reg_val;
    logic                func;
    logic [CHAN_W-1:0]   channel;
    logic [DATA_W-1:0]   duty;
    bit                  typed;
    logic [PWM_BITS-1:0] exp_pwm;
    logic [DATA_W-1:0]   exp_count;
  } stim_row_t;

  // Clock, reset and block ports; every input starts at a known value.
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 func = FUNC_TICK;
  logic [CHAN_W-1:0]    channel = '0;
  logic [DATA_W-1:0]    duty = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PWM_BITS-1:0]  pwm_out;
  logic [DATA_W-1:0]    count_value;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data = '0;

  // Predictor copy of the registers and the timer state.
  logic [DATA_W-1:0]   set_prescale = '0;
  logic [DATA_W-1:0]   set_period = 32'd1;
  logic [PWM_BITS-1:0] set_enable = '0;
  logic [DATA_W-1:0]   tmr_prescale_cnt = '0;
  logic [DATA_W-1:0]   tmr_period_cnt = '0;
  logic [DATA_W-1:0]   tmr_shadow [CHANNELS_DEF] = '{default: '0};
  logic [DATA_W-1:0]   tmr_active [CHANNELS_DEF] = '{default: '0};
  logic [PWM_BITS-1:0] tmr_pending = '0;

  result_t expected_results [$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned rcv_stall_pct = 0;

  // Directed table: reset behavior, invalid channels, duty extremes, the
  // latch on wrap, lowered prescale, shortened period, zero period and
  // disabled channels.
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    // reset state: period 1, all outputs disabled
    '{ROW_ITEM, REG_PRESCALE, 0, FUNC_TICK, 0, 0, 1, 6'd0, 32'd0},
    // duty writes to channel 0 and channel 7 are dropped
    '{ROW_ITEM, REG_PRESCALE, 0, FUNC_DUTY, 0, 5, 1, 6'd0, 32'd0},
    '{ROW_ITEM, REG_PRESCALE, 0, FUNC_DUTY, 7, 9, 1, 6'd0, 32'd0},
    '{ROW_CFG, REG_CHAN_ENABLE, 32'h3f, FUNC_TICK, 0, 0, 0, 6'd0, 32'd0},
    '{ROW_CFG, REG_PERIOD_TICKS, 32'd5, FUNC_TICK, 0, 0, 0, 6'd0, 32'd0},
    // writes sit in the shadows; active duties still zero
    '{ROW_ITEM, REG_PRESCALE, 0, FUNC_DUTY, 1, 32'hffff_ffff, 1, 6'd0, 32'd0},
    '{ROW_ITEM, REG_PRESCALE, 0, FUNC_DUTY, 6, 0, 1, 6'd0, 32'd0},
    '{ROW_ITEM, REG_PRESCALE, 0, FUNC_DUTY, 3, 2, 0, 6'd0, 32'd0},
    // run through one period, latch on the wrap
    '{ROW_ITEM, REG_PRESCALE, 0, FUNC_TICK, 0, 0, 0, 6'd0, 32'd0},
    '{ROW_ITEM, REG_PRESCALE, 0, FUNC_TICK, 0, 0, 0, 6'd0, 32'd0},
    '{ROW_ITEM, REG_PRESCALE, 0, FUNC_TICK, 0, 0, 0, 6'd0, 32'd0},
    '{ROW_ITEM, REG_PRESCALE, 0, FUNC_TICK, 0, 0, 0, 6'd0, 32'd0},
    '{ROW_ITEM, REG_PRESCALE, 0, FUNC_TICK, 0, 0, 0, 6'd0, 32'd0},
    '{ROW_ITEM, REG_PRESCALE, 0, FUNC_TICK, 0, 0, 0, 6'd0, 32'd0},
    // prescale raised, then lowered below the running prescale count
    '{ROW_CFG, REG_PRESCALE, 32'd3, FUNC_TICK, 0, 0, 0, 6'd0, 32'd0},
    '{ROW_ITEM, REG_PRESCALE, 0, FUNC_TICK, 0, 0, 0, 6'd0, 32'd0},
    '{ROW_ITEM, REG_PRESCALE, 0, FUNC_TICK, 0, 0, 0, 6'd0, 32'd0},
    '{ROW_CFG, REG_PRESCALE, 32'd0, FUNC_TICK, 0, 0, 0, 6'd0, 32'd0},
    '{ROW_ITEM, REG_PRESCALE, 0, FUNC_TICK, 0, 0, 0, 6'd0, 32'd0},
    // long period, climb, then shorten it under the counter
    '{ROW_CFG, REG_PERIOD_TICKS, 32'd20, FUNC_TICK, 0, 0, 0, 6'd0, 32'd0},
    '{ROW_ITEM, REG_PRESCALE, 0, FUNC_TICK, 0, 0, 0, 6'd0, 32'd0},
    '{ROW_ITEM, REG_PRESCALE, 0, FUNC_TICK, 0, 0, 0, 6'd0, 32'd0},
    '{ROW_ITEM, REG_PRESCALE, 0, FUNC_TICK, 0, 0, 0, 6'd0, 32'd0},
    '{ROW_ITEM, REG_PRESCALE, 0, FUNC_TICK, 0, 0, 0, 6'd0, 32'd0},
    '{ROW_CFG, REG_PERIOD_TICKS, 32'd2, FUNC_TICK, 0, 0, 0, 6'd0, 32'd0},
    '{ROW_ITEM, REG_PRESCALE, 0, FUNC_TICK, 0, 0, 0, 6'd0, 32'd0},
    // zero period behaves as one
    '{ROW_CFG, REG_PERIOD_TICKS, 32'd0, FUNC_TICK, 0, 0, 0, 6'd0, 32'd0},
    '{ROW_ITEM, REG_PRESCALE, 0, FUNC_TICK, 0, 0, 0, 6'd0, 32'd0},
    '{ROW_ITEM, REG_PRESCALE, 0, FUNC_TICK, 0, 0, 0, 6'd0, 32'd0},
    // some channels disabled, then all of them
    '{ROW_CFG, REG_CHAN_ENABLE, 32'h15, FUNC_TICK, 0, 0, 0, 6'd0, 32'd0},
    '{ROW_ITEM, REG_PRESCALE, 0, FUNC_TICK, 0, 0, 0, 6'd0, 32'd0},
    '{ROW_CFG, REG_CHAN_ENABLE, 32'h00, FUNC_TICK, 0, 0, 0, 6'd0, 32'd0},
    '{ROW_ITEM, REG_PRESCALE, 0, FUNC_DUTY, 2, 32'hffff_ffff, 0, 6'd0, 32'd0},
    '{ROW_ITEM, REG_PRESCALE, 0, FUNC_TICK, 0, 0, 0, 6'd0, 32'd0}
  };

  pwm_timer_shadow_match u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .channel     (channel),
    .duty        (duty),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pwm_out     (pwm_out),
    .count_value (count_value),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Advance the predicted timer by one request and return the pin levels
  // and period count that follow it.
  function automatic result_t timer_advance(item_t req);
    result_t     res;
    logic [32:0] next_cnt;
    logic [32:0] wrap_at;
    if (req.func == FUNC_TICK) begin
      if (tmr_prescale_cnt >= set_prescale) begin
        tmr_prescale_cnt = '0;
        next_cnt = {1'b0, tmr_period_cnt} + 33'd1;
        wrap_at  = (set_period == '0) ? 33'd1 : {1'b0, set_period};
        // Wrap on the period or on counter overflow; latch pending shadows.
        if (next_cnt >= wrap_at || next_cnt > 33'hffff_ffff) begin
          tmr_period_cnt = '0;
          for (int k = 0; k < CHANNELS_DEF; k++) begin
            if (tmr_pending[k]) tmr_active[k] = tmr_shadow[k];
          end
          tmr_pending = '0;
        end else begin
          tmr_period_cnt = next_cnt[DATA_W-1:0];
        end
      end else begin
        tmr_prescale_cnt = tmr_prescale_cnt + 32'd1;
      end
    end else if (req.channel >= 1 && req.channel <= CHANNELS_DEF) begin
      tmr_shadow[req.channel - 1]  = req.duty;
      tmr_pending[req.channel - 1] = 1'b1;
    end
    res.pwm_out = '0;
    for (int k = 0; k < CHANNELS_DEF; k++) begin
      if (set_enable[k] && tmr_period_cnt < tmr_active[k]) res.pwm_out[k] = 1'b1;
    end
    res.count_value = tmr_period_cnt;
    return res;
  endfunction

  // Offer one request after a random gap and hold it until it is taken.
  // Returns at the accepting edge with the request still driven.
  task automatic send_request(item_t req, bit typed, result_t typed_res);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= req.func;
    channel  <= req.channel;
    duty     <= req.duty;
    do @(posedge clk); while (in_stall);
    predicted = timer_advance(req);
    expected_results.push_back(typed ? typed_res : predicted);
  endtask

  // Drop valid and hold until every outstanding result has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Write one register; only called with the pipeline empty.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PRESCALE:     set_prescale = val;
      REG_PERIOD_TICKS: set_period   = val;
      REG_CHAN_ENABLE:  set_enable   = val[PWM_BITS-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: random stall, and compare each accepted result with the
  // oldest prediction.
  always @(posedge clk) begin : rx_check
    result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_stall_pct);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: pwm_out=%h count_value=%h", pwm_out, count_value);
        end else begin
          want = expected_results.pop_front();
          if (pwm_out !== want.pwm_out || count_value !== want.count_value) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: pwm_out exp %h got %h, count_value exp %h got %h",
                       want.pwm_out, pwm_out, want.count_value, count_value);
          end
        end
      end
    end
  end

  // Main sequence: reset, directed table, then randomized phases.
  initial begin : stimulus
    item_t       req;
    result_t     typed_res;
    logic [DATA_W-1:0]   new_prescale;
    logic [DATA_W-1:0]   new_period;
    logic [PWM_BITS-1:0] new_enable;
    int unsigned span;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, no idling.
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        wait_idle();
        write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_val);
      end else begin
        req.func              = directed_rows[r].func;
        req.channel           = directed_rows[r].channel;
        req.duty              = directed_rows[r].duty;
        typed_res.pwm_out     = directed_rows[r].exp_pwm;
        typed_res.count_value = directed_rows[r].exp_count;
        send_request(req, directed_rows[r].typed, typed_res);
      end
    end

    // Random part: each phase picks new registers and an idling mode.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; rcv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rcv_stall_pct = 83; end
        default: begin send_idle_pct = 23; rcv_stall_pct = 23; end
      endcase
      new_enable = PWM_BITS'($urandom_range(63));
      case (ph)
        0: begin new_prescale = 0; new_period = 4; new_enable = '1; end
        1: begin new_prescale = 2; new_period = 7; end
        2: begin new_prescale = 0; new_period = 0; new_enable = '1; end
        3: begin new_prescale = 32'hffff_ffff; new_period = 3; new_enable = '1; end
        4: begin new_prescale = 1; new_period = 1; end
        5: begin new_prescale = 0; new_period = 32'hffff_ffff; new_enable = '1; end
        // Short period after the long climb: the counter is past it.
        6: begin new_prescale = $urandom_range(3); new_period = $urandom_range(12, 2); end
        7: begin new_prescale = $urandom(); new_period = $urandom(); end
        // Small prescale after a random one: lowered under the count.
        default: begin
          new_prescale = 0; new_period = $urandom_range(9, 2); new_enable = '1;
        end
      endcase
      wait_idle();
      write_reg(REG_PRESCALE, new_prescale);
      write_reg(REG_PERIOD_TICKS, new_period);
      write_reg(REG_CHAN_ENABLE, {26'd0, new_enable});

      span = (set_period < 100) ? set_period + 1 : 100;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Now and then hold off until the block has drained.
        if ($urandom_range(49) == 0) wait_idle();
        req.func    = ($urandom_range(9) < 7) ? FUNC_TICK : FUNC_DUTY;
        req.channel = ($urandom_range(15) == 0) ? ($urandom_range(1) ? 3'd7 : 3'd0)
                                                : 3'($urandom_range(6, 1));
        case ($urandom_range(9))
          0:       req.duty = '0;
          1:       req.duty = '1;
          2, 3:    req.duty = $urandom();
          default: req.duty = $urandom_range(span);
        endcase
        send_request(req, 1'b0, typed_res);
      end
    end

    // Drain, then give the block a few more cycles to show stray results.
    wait_idle();
    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived", expected_results.size());
    end
    if (mismatches == 0) begin
      $display("pwm_timer_shadow_match test passed");
    end else begin
      $display("pwm_timer_shadow_match test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #(5_000_000);
    $display("pwm_timer_shadow_match test failed");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/pwmtsm_pkg.sv
rtl/core/pwmtsm_cfg_regs.sv
rtl/core/pwmtsm_in_reg.sv
rtl/core/pwmtsm_core.sv
rtl/core/pwmtsm_out_reg.sv
rtl/core/pwm_timer_shadow_match.sv
rtl/core/pwmtsm_checker.sv
bench/pwm_timer_shadow_match_tb.sv
